FILE: rtl/mefuf_pkg.sv
package mefuf_pkg;

  // fixed field widths
  localparam int NODE_W   = 8;
  localparam int WEIGHT_W = 24;
  localparam int COUNT_W  = 9;
  localparam int RANK_W   = 4;

  // saturation point of the rank counter
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one classified edge waiting for the back end
  typedef struct packed {
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                err;
  } edge_item_t;

  // one result leaving the block
  typedef struct packed {
    logic                accepted;
    logic [NODE_W-1:0]   edge_a;
    logic [NODE_W-1:0]   edge_b;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                tree_done;
    logic                node_error;
  } edge_result_t;

  // store control from the configuration side
  typedef struct packed {
    logic               reinit;
    logic [COUNT_W-1:0] active;
  } store_ctl_t;

endpackage

FILE: rtl/mefuf_ram.sv
module mefuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mefuf_queue.sv
module mefuf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mefuf_pkg::edge_item_t  push_item,
  output logic                   full,
  output logic                   q_valid,
  input  logic                   q_ready,
  output mefuf_pkg::edge_item_t  q_item
);
  import mefuf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  edge_item_t       entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entry[rd_ptr];
  assign pop     = q_valid && q_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

endmodule

FILE: rtl/mefuf_front.sv
module mefuf_front #(
  parameter int MAX_NODES = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mefuf_pkg::COUNT_W-1:0]      node_count,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mefuf_pkg::NODE_W-1:0]       node_a,
  input  logic [mefuf_pkg::NODE_W-1:0]       node_b,
  input  logic [mefuf_pkg::WEIGHT_W-1:0]     weight,
  input  logic                               clearing,
  input  logic                               q_full,
  output logic                               push,
  output mefuf_pkg::edge_item_t              push_item,
  output mefuf_pkg::store_ctl_t              ctl
);
  import mefuf_pkg::*;

  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int CAP_INT   = (MAX_NODES > COUNT_MAX) ? COUNT_MAX : MAX_NODES;
  localparam int RST_INT   = (MAX_NODES < 256) ? MAX_NODES : 256;
  localparam logic [COUNT_W-1:0] CAP          = COUNT_W'(CAP_INT);
  localparam logic [COUNT_W-1:0] RESET_ACTIVE = COUNT_W'(RST_INT);

  logic               cfg_fire;
  logic [COUNT_W-1:0] cfg_active;
  logic [COUNT_W-1:0] active;
  logic               reinit;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // zero counts as one node, counts above capacity saturate
  always_comb begin
    if (node_count == '0) begin
      cfg_active = COUNT_W'(1);
    end else if (node_count > CAP) begin
      cfg_active = CAP;
    end else begin
      cfg_active = node_count;
    end
  end

  // node count register and store reinit pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= RESET_ACTIVE;
      reinit <= 1'b1;
    end else begin
      reinit <= cfg_fire;
      if (cfg_fire) begin
        active <= cfg_active;
      end
    end
  end

  assign ctl.reinit = reinit;
  assign ctl.active = active;

  // classify: range check against the node count
  assign in_ready         = !q_full && !clearing;
  assign push             = in_valid && in_ready;
  assign push_item.node_a = node_a;
  assign push_item.node_b = node_b;
  assign push_item.weight = weight;
  assign push_item.err    = (COUNT_W'(node_a) >= active) || (COUNT_W'(node_b) >= active);

  a_cfg_reinit: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> ctl.reinit && (ctl.active != '0))
    else $error("node count transfer did not restart the store");

endmodule

FILE: rtl/mefuf_back.sv
module mefuf_back #(
  parameter int MAX_NODES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mefuf_pkg::store_ctl_t     ctl,
  input  logic                      q_valid,
  output logic                      q_ready,
  input  mefuf_pkg::edge_item_t     q_item,
  output logic                      clearing,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mefuf_pkg::edge_result_t   res
);
  import mefuf_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PAR   = 6'b000100,
    S_GP    = 6'b001000,
    S_RANK  = 6'b010000,
    S_OUT   = 6'b100000
  } back_state_t;

  back_state_t        state, state_next;
  logic [IW-1:0]      x, x_next;
  logic [IW-1:0]      ra, ra_next;
  logic [IW-1:0]      rb, rb_next;
  logic [IW-1:0]      clr_idx, clr_idx_next;
  logic [RANK_W-1:0]  rank_a, rank_a_next;
  logic               which, which_next;
  logic               acc, acc_next;
  edge_item_t         item, item_next;
  logic [COUNT_W-1:0] set_count, set_count_next;
  logic [IW-1:0]      active_m1;

  // memory ports
  logic              par_we, par_re;
  logic [IW-1:0]     par_waddr, par_wdata, par_raddr, par_rdata;
  logic              rank_we, rank_re;
  logic [IW-1:0]     rank_waddr, rank_raddr;
  logic [RANK_W-1:0] rank_wdata, rank_rdata;

  mefuf_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .re    (par_re),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  mefuf_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .re    (rank_re),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  assign active_m1 = IW'(ctl.active - COUNT_W'(1));
  assign clearing  = (state == S_CLEAR);

  // sequencer: clear pass, two root searches with path halving, union by rank
  always_comb begin
    logic [RANK_W-1:0] rank_b;
    logic [IW-1:0]     hi_node;
    logic [IW-1:0]     lo_node;

    state_next     = state;
    x_next         = x;
    ra_next        = ra;
    rb_next        = rb;
    clr_idx_next   = clr_idx;
    rank_a_next    = rank_a;
    which_next     = which;
    acc_next       = acc;
    item_next      = item;
    set_count_next = set_count;
    q_ready        = 1'b0;
    par_we         = 1'b0;
    par_waddr      = x;
    par_wdata      = x;
    par_re         = 1'b0;
    par_raddr      = x;
    rank_we        = 1'b0;
    rank_waddr     = x;
    rank_wdata     = '0;
    rank_re        = 1'b0;
    rank_raddr     = x;
    rank_b         = rank_rdata;
    hi_node        = ra;
    lo_node        = rb;

    case (state)
      S_CLEAR: begin
        par_we     = 1'b1;
        par_waddr  = clr_idx;
        par_wdata  = clr_idx;
        rank_we    = 1'b1;
        rank_waddr = clr_idx;
        rank_wdata = '0;
        if (clr_idx == active_m1) begin
          state_next = S_IDLE;
        end else begin
          clr_idx_next = clr_idx + IW'(1);
        end
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          item_next = q_item;
          acc_next  = 1'b0;
          if (q_item.err || set_count == COUNT_W'(1)) begin
            state_next = S_OUT;
          end else begin
            par_re     = 1'b1;
            par_raddr  = IW'(q_item.node_a);
            x_next     = IW'(q_item.node_a);
            which_next = 1'b0;
            state_next = S_PAR;
          end
        end
      end
      S_PAR: begin
        if (par_rdata == x) begin
          if (!which) begin
            // root of the first endpoint found, start on the second
            ra_next    = x;
            rank_re    = 1'b1;
            rank_raddr = x;
            which_next = 1'b1;
            x_next     = IW'(item.node_b);
            par_re     = 1'b1;
            par_raddr  = IW'(item.node_b);
          end else begin
            rb_next = x;
            if (x == ra) begin
              state_next = S_OUT;
            end else begin
              rank_a_next = rank_rdata;
              rank_re     = 1'b1;
              rank_raddr  = x;
              state_next  = S_RANK;
            end
          end
        end else begin
          par_re     = 1'b1;
          par_raddr  = par_rdata;
          state_next = S_GP;
        end
      end
      S_GP: begin
        // halve the path: point x at its grandparent and move there
        par_we     = 1'b1;
        par_waddr  = x;
        par_wdata  = par_rdata;
        x_next     = par_rdata;
        par_re     = 1'b1;
        par_raddr  = par_rdata;
        state_next = S_PAR;
      end
      S_RANK: begin
        rank_b = rank_rdata;
        if (rank_a < rank_b) begin
          hi_node = rb;
          lo_node = ra;
        end else begin
          hi_node = ra;
          lo_node = rb;
        end
        par_we    = 1'b1;
        par_waddr = lo_node;
        par_wdata = hi_node;
        if (rank_a == rank_b && rank_a != RANK_MAX) begin
          rank_we    = 1'b1;
          rank_waddr = hi_node;
          rank_wdata = rank_a + RANK_W'(1);
        end
        if (set_count != '0) begin
          set_count_next = set_count - COUNT_W'(1);
        end
        acc_next   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // a new node count restarts the store
    if (ctl.reinit) begin
      state_next     = S_CLEAR;
      clr_idx_next   = '0;
      set_count_next = ctl.active;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      set_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      set_count <= set_count_next;
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    x      <= x_next;
    ra     <= ra_next;
    rb     <= rb_next;
    rank_a <= rank_a_next;
    which  <= which_next;
    acc    <= acc_next;
    item   <= item_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      res.accepted    <= acc;
      res.edge_a      <= item.node_a;
      res.edge_b      <= item.node_b;
      res.edge_weight <= item.weight;
      res.tree_done   <= (set_count == COUNT_W'(1));
      res.node_error  <= item.err;
    end
  end

  a_merge_distinct_roots: assert property (@(posedge clk) disable iff (rst)
    (state == S_RANK) |-> (ra != rb))
    else $error("merge between equal roots");

  a_merge_drops_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RANK && !ctl.reinit) |=> (set_count == $past(set_count) - COUNT_W'(1)))
    else $error("merge did not reduce the set count");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |-> (set_count != '0))
    else $error("set count reached zero");

endmodule

FILE: rtl/mst_edge_filter_union_find.sv
// Kruskal edge filter over a disjoint-set store. Feed edges in ascending weight
// order; each edge gives one result that echoes it and says whether it joined two
// sets (accepted), whether one set now remains (tree_done) and whether an endpoint
// was not below the node count in use (node_error). An edge is rejected up front
// on a range error or a complete tree; otherwise the engine runs two root searches
// with path halving and, when the roots differ, a merge by rank. The pace of a
// root search is set by the single read port of the parent memory, which every
// step of a root search goes through. After reset and after each node_count write
// the store runs a clearing pass over every node in use (MAX_NODES, at most 256,
// after reset) with in_ready low. A two-entry queue sits between the input side
// and the search engine, and the result sits in an output register, so input
// keeps flowing while a result waits, until the queue is full.
module mst_edge_filter_union_find #(
  parameter int MAX_NODES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mefuf_pkg::COUNT_W-1:0]  node_count,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mefuf_pkg::NODE_W-1:0]   node_a,
  input  logic [mefuf_pkg::NODE_W-1:0]   node_b,
  input  logic [mefuf_pkg::WEIGHT_W-1:0] weight,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           accepted,
  output logic [mefuf_pkg::NODE_W-1:0]   edge_a,
  output logic [mefuf_pkg::NODE_W-1:0]   edge_b,
  output logic [mefuf_pkg::WEIGHT_W-1:0] edge_weight,
  output logic                           tree_done,
  output logic                           node_error
);
  import mefuf_pkg::*;

  logic         clearing;
  logic         q_full;
  logic         push;
  edge_item_t   push_item;
  store_ctl_t   ctl;
  logic         q_valid;
  logic         q_ready;
  edge_item_t   q_item;
  edge_result_t res;

  // input side: node count register and range check
  mefuf_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .node_count (node_count),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .node_a     (node_a),
    .node_b     (node_b),
    .weight     (weight),
    .clearing   (clearing),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item),
    .ctl        (ctl)
  );

  // classified edges waiting for the search engine
  mefuf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // root searches, merge and result register
  mefuf_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign accepted    = res.accepted;
  assign edge_a      = res.edge_a;
  assign edge_b      = res.edge_b;
  assign edge_weight = res.edge_weight;
  assign tree_done   = res.tree_done;
  assign node_error  = res.node_error;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mefuf_pkg::*;

  localparam int unsigned NODE_CAP   = 256;
  localparam int unsigned EDGE_TOTAL = 1420;
  localparam int unsigned HOLD_AT    = 1000;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned PHASE_CAP  = 600;

  typedef enum bit [1:0] {ROW_CFG, ROW_EDGE, ROW_TYPED} row_kind_t;

  // one line of the directed plan
  typedef struct {
    row_kind_t           kind;
    logic [COUNT_W-1:0]  count;
    logic [NODE_W-1:0]   a;
    logic [NODE_W-1:0]   b;
    logic [WEIGHT_W-1:0] w;
    logic                acc;
    logic                done;
    logic                err;
  } plan_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  node_count = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [NODE_W-1:0]   node_a = '0;
  logic [NODE_W-1:0]   node_b = '0;
  logic [WEIGHT_W-1:0] weight = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                accepted;
  logic [NODE_W-1:0]   edge_a;
  logic [NODE_W-1:0]   edge_b;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                tree_done;
  logic                node_error;

  // disjoint-set mirror of the block
  logic [NODE_W-1:0]   forest_parent [NODE_CAP];
  logic [RANK_W-1:0]   forest_rank [NODE_CAP];
  int unsigned         sets_left;
  int unsigned         nodes_live;

  edge_result_t        pending_results [$];
  plan_row_t           plan [$];
  int unsigned         edges_sent = 0;
  int unsigned         results_seen = 0;
  int unsigned         mismatches = 0;
  int unsigned         cycles = 0;
  logic                steady;

  assign steady = (edges_sent >= 400) && (edges_sent < 700);

  mst_edge_filter_union_find u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .node_count  (node_count),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .node_a      (node_a),
    .node_b      (node_b),
    .weight      (weight),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .edge_a      (edge_a),
    .edge_b      (edge_b),
    .edge_weight (edge_weight),
    .tree_done   (tree_done),
    .node_error  (node_error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // every node its own set; zero counts as one, large counts clip to capacity
  function automatic void clear_forest(input logic [COUNT_W-1:0] count);
    int unsigned c;
    c = 32'(count);
    if (c == 0) c = 1;
    if (c > NODE_CAP) c = NODE_CAP;
    nodes_live = c;
    sets_left  = c;
    for (int k = 0; k < NODE_CAP; k++) begin
      forest_parent[k] = NODE_W'(k);
      forest_rank[k]   = '0;
    end
  endfunction

  // root search with path halving
  function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] x);
    logic [NODE_W-1:0] gp;
    while (forest_parent[x] != x) begin
      gp = forest_parent[forest_parent[x]];
      forest_parent[x] = gp;
      x = gp;
    end
    return x;
  endfunction

  // verdict for one edge, updating the mirror
  function automatic edge_result_t classify_edge(input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b,
                                                 input logic [WEIGHT_W-1:0] w);
    edge_result_t r;
    logic [NODE_W-1:0] ra, rb, t;
    r = '0;
    r.edge_a = a;
    r.edge_b = b;
    r.edge_weight = w;
    if (32'(a) >= nodes_live || 32'(b) >= nodes_live) begin
      r.node_error = 1'b1;
    end else if (sets_left != 1) begin
      ra = find_root(a);
      rb = find_root(b);
      if (ra != rb) begin
        if (forest_rank[ra] < forest_rank[rb]) begin
          t = ra;
          ra = rb;
          rb = t;
        end
        forest_parent[rb] = ra;
        if (forest_rank[ra] == forest_rank[rb] && forest_rank[ra] != RANK_MAX)
          forest_rank[ra] = forest_rank[ra] + RANK_W'(1);
        if (sets_left > 0) sets_left--;
        r.accepted = 1'b1;
      end
    end
    r.tree_done = (sets_left == 1);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at result %0d: got %0h want %0h",
             what, results_seen, got, want);
    mismatches++;
  endtask

  // node count write, only with nothing in flight
  task automatic write_node_count(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid  <= 1'b1;
    node_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clear_forest(value);
  endtask

  // offer one edge, keeping valid up when no gap is taken
  task automatic send_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                           input logic [WEIGHT_W-1:0] w, output edge_result_t verdict);
    if (!steady && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(0, 99) < 38);
    end
    in_valid <= 1'b1;
    node_a   <= a;
    node_b   <= b;
    weight   <= w;
    do @(posedge clk); while (!in_ready);
    verdict = classify_edge(a, b, w);
    edges_sent++;
  endtask

  // result side: random stalls, one long hold-off while edges keep coming
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && edges_sent >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        held = 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  // compare each result transfer with the oldest verdict
  always @(posedge clk) begin
    edge_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", edge_a, 0);
      end else begin
        want = pending_results.pop_front();
        if (accepted !== want.accepted) flag_mismatch("accepted", accepted, want.accepted);
        if (edge_a !== want.edge_a) flag_mismatch("edge_a", edge_a, want.edge_a);
        if (edge_b !== want.edge_b) flag_mismatch("edge_b", edge_b, want.edge_b);
        if (edge_weight !== want.edge_weight)
          flag_mismatch("edge_weight", edge_weight, want.edge_weight);
        if (tree_done !== want.tree_done) flag_mismatch("tree_done", tree_done, want.tree_done);
        if (node_error !== want.node_error)
          flag_mismatch("node_error", node_error, want.node_error);
      end
      results_seen++;
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("mst_edge_filter_union_find regression: fail");
    $finish;
  end

  initial begin
    edge_result_t        verdict;
    logic [COUNT_W-1:0]  phase_count;
    logic [NODE_W-1:0]   a, b, t;
    int unsigned         chain_next, extra, phase_edges, pick;

    clear_forest(COUNT_W'(NODE_CAP));

    plan = '{
      // fresh store after reset
      '{ROW_TYPED, 9'd0,   8'd0,   8'd255, 24'h000000, 1'b1, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd255, 8'd0,   24'hFFFFFF, 1'b0, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd5,   8'd5,   24'h123456, 1'b0, 1'b0, 1'b0},
      // zero count acts as a single node, tree complete at once
      '{ROW_CFG,   9'd0,   8'd0,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd0,   8'd0,   24'h000001, 1'b0, 1'b1, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd1,   8'd0,   24'h000002, 1'b0, 1'b1, 1'b1},
      '{ROW_CFG,   9'd2,   8'd0,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd0,   8'd2,   24'h000003, 1'b0, 1'b0, 1'b1},
      '{ROW_TYPED, 9'd0,   8'd1,   8'd0,   24'h000004, 1'b1, 1'b1, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd0,   8'd1,   24'h000005, 1'b0, 1'b1, 1'b0},
      // counts above capacity clip to it
      '{ROW_CFG,   9'd511, 8'd0,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd255, 8'd254, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
      '{ROW_EDGE,  9'd0,   8'd254, 8'd255, 24'h800000, 1'b0, 1'b0, 1'b0},
      '{ROW_CFG,   9'd257, 8'd0,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_EDGE,  9'd0,   8'd128, 8'd127, 24'h7FFFFF, 1'b0, 1'b0, 1'b0},
      // four nodes joined, then rejects once complete
      '{ROW_CFG,   9'd4,   8'd0,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_EDGE,  9'd0,   8'd0,   8'd1,   24'h000010, 1'b0, 1'b0, 1'b0},
      '{ROW_EDGE,  9'd0,   8'd2,   8'd3,   24'h000011, 1'b0, 1'b0, 1'b0},
      '{ROW_EDGE,  9'd0,   8'd1,   8'd3,   24'h000012, 1'b0, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd0,   8'd2,   24'h000013, 1'b0, 1'b1, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd4,   8'd0,   24'h000014, 1'b0, 1'b1, 1'b1},
      '{ROW_TYPED, 9'd0,   8'd0,   8'd255, 24'h000015, 1'b0, 1'b1, 1'b1},
      '{ROW_CFG,   9'd3,   8'd0,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd2,   8'd2,   24'hABCDEF, 1'b0, 1'b0, 1'b0},
      '{ROW_TYPED, 9'd0,   8'd3,   8'd0,   24'h555555, 1'b0, 1'b0, 1'b1},
      '{ROW_EDGE,  9'd0,   8'd2,   8'd0,   24'hAAAAAA, 1'b0, 1'b0, 1'b0}
    };

    // reset
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_node_count(plan[i].count);
      end else begin
        send_edge(plan[i].a, plan[i].b, plan[i].w, verdict);
        if (plan[i].kind == ROW_TYPED) begin
          verdict.accepted   = plan[i].acc;
          verdict.tree_done  = plan[i].done;
          verdict.node_error = plan[i].err;
        end
        pending_results.insert(pending_results.size(), verdict);
      end
    end

    // random phases: mostly spanning sequences with random shape, some noise
    while (edges_sent < EDGE_TOTAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       phase_count = COUNT_W'($urandom_range(256, 511));
      else if (pick < 20) phase_count = COUNT_W'($urandom_range(33, 128));
      else if (pick < 23) phase_count = '0;
      else                phase_count = COUNT_W'($urandom_range(1, 32));
      write_node_count(phase_count);
      chain_next  = 1;
      extra       = $urandom_range(1, 4);
      phase_edges = 0;
      while (edges_sent < EDGE_TOTAL && phase_edges < PHASE_CAP
             && !(sets_left == 1 && extra == 0)) begin
        if (sets_left == 1) extra--;
        pick = $urandom_range(0, 99);
        if (pick < 55 && chain_next < nodes_live) begin
          a = NODE_W'(chain_next);
          b = NODE_W'($urandom_range(0, chain_next - 1));
          chain_next++;
        end else if (pick < 95 && pick >= 85 && nodes_live < NODE_CAP) begin
          a = NODE_W'($urandom_range(nodes_live, NODE_CAP - 1));
          b = NODE_W'($urandom_range(0, NODE_CAP - 1));
        end else if (pick >= 95) begin
          a = NODE_W'($urandom_range(0, nodes_live - 1));
          b = a;
        end else begin
          a = NODE_W'($urandom_range(0, nodes_live - 1));
          b = NODE_W'($urandom_range(0, nodes_live - 1));
        end
        if ($urandom_range(0, 1) == 1) begin
          t = a;
          a = b;
          b = t;
        end
        send_edge(a, b, WEIGHT_W'($urandom()), verdict);
        pending_results.insert(pending_results.size(), verdict);
        phase_edges++;
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("mst_edge_filter_union_find regression: pass");
    else
      $display("mst_edge_filter_union_find regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/mefuf_pkg.sv
rtl/mefuf_ram.sv
rtl/mefuf_queue.sv
rtl/mefuf_front.sv
rtl/mefuf_back.sv
rtl/mst_edge_filter_union_find.sv
tb/testbench.sv
